>>> rtl/core/rain_shift_sparkle_strip_assert.svh
// Assertion macros for the rain strip block.
// Each macro expects clk_i and rst_ni in scope.
`ifndef RAIN_SHIFT_SPARKLE_STRIP_ASSERT_SVH
`define RAIN_SHIFT_SPARKLE_STRIP_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define RSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define RSS_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define RSS_ASSERT(lbl, prop, msg)
`define RSS_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

>>> rtl/core/rss_pkg.sv
package rss_pkg;

  localparam int unsigned LED_COUNT  = 32;
  localparam int unsigned IDX_W      = $clog2(LED_COUNT);
  localparam int unsigned RND_W      = 16;
  localparam int unsigned PIX_IDX_W  = 5;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam int unsigned OFFSET_BASE = 100;
  localparam int unsigned OFFSET_STEP = 25;
  localparam int unsigned CHAN_MAX    = 255;

  localparam logic [2:0] STAGE_DIM    = 3'd1;
  localparam logic [2:0] STAGE_PLAIN0 = 3'd2;
  localparam logic [2:0] STAGE_PLAIN1 = 3'd3;
  localparam logic [2:0] STAGE_GLOW   = 3'd4;
  localparam logic [2:0] STAGE_BRIGHT = 3'd5;
  localparam logic [2:0] STAGE_WHITE  = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_BASE_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE  = 2'd2;

  typedef struct packed {
    logic [2:0]       stage;
    logic [RND_W-1:0] random_value;
  } in_t;

  typedef struct packed {
    logic                 frame_pass;
    logic [PIX_IDX_W-1:0] pixel_index;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;
    logic                 last;
  } out_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic             load;
    logic             emit;
    logic             pass;
    logic [IDX_W-1:0] index;
    logic             last;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } status_t;

  function automatic logic [7:0] stage_chan(input logic [2:0] stage, input logic rnd_lsb,
                                            input logic [7:0] c);
    logic [8:0] sum_hi;
    logic [8:0] sum_lo;
    logic [7:0] res;
    sum_hi = {1'b0, c} + 9'(OFFSET_BASE - 2 * OFFSET_STEP);
    sum_lo = {1'b0, c} + 9'(OFFSET_BASE - 3 * OFFSET_STEP);
    case (stage)
      STAGE_WHITE:  res = 8'(CHAN_MAX);
      STAGE_BRIGHT: res = (sum_hi > 9'(CHAN_MAX)) ? 8'(CHAN_MAX) : sum_hi[7:0];
      STAGE_GLOW:   res = (sum_lo > 9'(CHAN_MAX)) ? 8'(CHAN_MAX) : sum_lo[7:0];
      STAGE_PLAIN0,
      STAGE_PLAIN1: res = c;
      STAGE_DIM: begin
        if (rnd_lsb) begin
          res = (c >= 8'(OFFSET_STEP)) ? c - 8'(OFFSET_STEP) : 8'd0;
        end else begin
          res = {1'b0, c[7:1]};
        end
      end
      default:      res = c;
    endcase
    return res;
  endfunction

endpackage

>>> rtl/core/rss_datapath.sv
module rss_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  rss_pkg::in_t                  in_data_i,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i,
  input  rss_pkg::cmd_t                 cmd_i,
  output rss_pkg::status_t              status_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rss_pkg::out_t                 out_data_o
);
  import rss_pkg::*;

  pixel_t           base_q;
  pixel_t           pix_q [LED_COUNT];
  pixel_t           new_pix;
  logic [RND_W-1:0] rnd_mod;
  logic [IDX_W-1:0] rem_q;
  logic             out_valid_q;
  out_t             out_q, out_d;
  logic             sparkle;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BASE_RED:   base_q.red   <= cfg_data_i;
        REG_BASE_GREEN: base_q.green <= cfg_data_i;
        REG_BASE_BLUE:  base_q.blue  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    new_pix.red   = stage_chan(in_data_i.stage, in_data_i.random_value[0], base_q.red);
    new_pix.green = stage_chan(in_data_i.stage, in_data_i.random_value[0], base_q.green);
    new_pix.blue  = stage_chan(in_data_i.stage, in_data_i.random_value[0], base_q.blue);
  end

  // Strip as a shift line: load shifts down, emit rotates so tap 0 walks the strip.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < LED_COUNT; k++) begin
        pix_q[k] <= '0;
      end
    end else if (cmd_i.load) begin
      pix_q[0] <= new_pix;
      for (int k = 1; k < LED_COUNT; k++) begin
        pix_q[k] <= pix_q[k-1];
      end
    end else if (cmd_i.emit) begin
      for (int k = 0; k < LED_COUNT - 1; k++) begin
        pix_q[k] <= pix_q[k+1];
      end
      pix_q[LED_COUNT-1] <= pix_q[0];
    end
  end

  // LED count is a power of two, so the sparkle position is just the low bits
  assign rnd_mod = in_data_i.random_value % RND_W'(LED_COUNT);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rem_q <= rnd_mod[IDX_W-1:0];
    end
  end

  assign sparkle = !cmd_i.pass && (cmd_i.index == rem_q);

  always_comb begin
    out_d.frame_pass  = cmd_i.pass;
    out_d.pixel_index = PIX_IDX_W'(cmd_i.index);
    out_d.last        = cmd_i.last;
    out_d.red         = pix_q[0].red;
    out_d.green       = pix_q[0].green;
    out_d.blue        = pix_q[0].blue;
    if (sparkle) begin
      out_d.red   = {pix_q[0].red[6:0], 1'b0};
      out_d.green = {pix_q[0].green[6:0], 1'b0};
      out_d.blue  = {pix_q[0].blue[6:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q <= out_d;
    end
  end

  assign status_o.slot_free = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_data_o         = out_q;

endmodule

>>> rtl/core/rss_ctrl.sv
module rss_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  rss_pkg::status_t status_i,
  output rss_pkg::cmd_t    cmd_o
);
  import rss_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             pass_q, pass_d;
  logic             idx_end;

  assign idx_end    = (idx_q == IDX_W'(LED_COUNT - 1));
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    pass_d        = pass_q;
    cmd_o.load     = 1'b0;
    cmd_o.emit     = 1'b0;
    cmd_o.pass     = pass_q;
    cmd_o.index    = idx_q;
    cmd_o.last     = pass_q && idx_end;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          idx_d      = '0;
          pass_d     = 1'b0;
          state_d    = S_EMIT;
        end
      end
      S_EMIT: begin
        if (status_i.slot_free) begin
          cmd_o.emit = 1'b1;
          idx_d      = idx_q + 1'b1;
          if (idx_end) begin
            idx_d = '0;
            if (pass_q) begin
              state_d = S_IDLE;
            end else begin
              pass_d = 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pass_q  <= pass_d;
    end
  end

`include "rain_shift_sparkle_strip_assert.svh"

  `RSS_ASSERT_NEVER(a_emit_needs_slot, cmd_o.emit && !status_i.slot_free, "emit into full slot")
  `RSS_ASSERT_NEVER(a_load_emit_excl, cmd_o.load && cmd_o.emit, "load overlap")
  `RSS_ASSERT(a_transfer_starts_emit, (in_valid_i && in_ready_o) |=> (state_q == S_EMIT), "no emit")
  `RSS_ASSERT(a_last_ends_item, (cmd_o.emit && cmd_o.last) |=> (state_q == S_IDLE), "no idle")

endmodule

>>> rtl/core/rain_shift_sparkle_strip.sv
// After the input transfer, the first result passes the strip load register and then the output
// register before it is valid; then one pixel per cycle while the output side is ready.
// Each item takes a load, then the two passes over the strip shift line at one pixel per cycle;
// output stalls hold the passes, and no new item is taken until both passes are done.
// Reset (async, active low) clears the strip and the base color to zero and idles the
// controller; the block is ready the first cycle after reset.
module rain_shift_sparkle_strip (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  rss_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output rss_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rss_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [7:0]                    cfg_data_i
);
  import rss_pkg::*;

  cmd_t    cmd;
  status_t status;

  rss_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rss_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
